// ===== rtl/lz4bd_pkg.sv =====
// Shared types, codes and defaults for the LZ4 block decompressor.
package lz4bd_pkg;

  // default output capacity and reset value of the capacity register
  localparam int OutCapDefault = 4096;
  localparam int CapReset      = 4096;
  localparam int MinMatch      = 4;

  // request function codes
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_SRC   = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // run status codes
  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // one request
  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  data_byte;
    logic        last;
    logic [11:0] read_addr;
  } lz4bd_item_t;

  // one result
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  read_data;
    logic [12:0] out_length;
  } lz4bd_result_t;

  // match copy engine status
  typedef struct packed {
    logic busy;
    logic done;
  } lz4bd_copy_stat_t;

endpackage

// ===== rtl/lz4_block_decompressor_core.sv =====
// LZ4 block decompressor: one request in, one result out, history RAM inside.
// Timing: start, source and unused-code requests give their result in the cycle after
// accept; a read returns through the RAM read register and then the result register; a
// source byte that ends a match runs the copy engine over match_length bytes (4..OUT_CAP-1),
// one history byte per cycle. Next request is taken once the result register is free and the core is idle.
// Reset (synchronous, rst high): capacity register 4096, new block started.
module lz4_block_decompressor_core import lz4bd_pkg::*; #(
  parameter int OUT_CAP = OutCapDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  lz4bd_item_t   item,
  output logic          res_valid,
  input  logic          res_ready,
  output lz4bd_result_t res,
  input  logic          cfg_we,
  input  logic [12:0]   cfg_wdata
);

  localparam int AW = $clog2(OUT_CAP);
  localparam int CW = $clog2(OUT_CAP + 1);
  localparam int LW = $clog2(OUT_CAP + 6);
  localparam int SW = ((LW > 8) ? LW : 8) + 1;
  localparam int OW = (CW > 16) ? CW : 16;
  localparam int KW = (CW > 13) ? CW : 13;
  localparam int RW = (CW > 12) ? CW : 12;
  localparam int LenSat = OUT_CAP + 1;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_COPY} state_t;
  typedef enum logic [2:0] {
    PH_TOKEN, PH_LITLEN, PH_LITERALS, PH_OFF_LO, PH_OFF_HI, PH_MATCHLEN
  } phase_t;

  // clamp the capacity register to the history depth
  function automatic logic [CW-1:0] cap_of(input logic [12:0] c);
    cap_of = (KW'(c) > KW'(OUT_CAP)) ? CW'(OUT_CAP) : CW'(c);
  endfunction

  state_t        state;
  phase_t        phase, phase_next;
  logic [12:0]   cfg_cap;
  logic [CW-1:0] block_cap;
  logic [CW-1:0] prod, prod_next;
  logic [LW-1:0] len, len_next;
  logic [3:0]    nib, nib_next;
  logic [7:0]    offlo, offlo_next;
  logic [15:0]   off, off_next;
  logic [1:0]    run_st, status_next;
  logic [LW-1:0] mlen;
  logic          last_q;
  logic          rd_hit;

  logic          acc, src_go, rd_go;
  logic [7:0]    b;
  logic [SW-1:0] sum_w;
  logic [LW-1:0] sat_len;
  logic [LW-1:0] cmp_len;
  logic [CW-1:0] space;
  logic          too_long;
  logic          begin_lit, do_match;
  logic          lit_we, copy_go;
  logic [15:0]   off_val;
  logic [CW-1:0] new_cap;
  logic [CW-1:0] copy_end;
  logic          in_range;

  logic             copy_re, copy_we;
  logic [AW-1:0]    copy_raddr, copy_waddr;
  logic [7:0]       copy_wdata;
  lz4bd_copy_stat_t cstat;
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;

  assign item_ready = (state == S_IDLE) && (!res_valid || res_ready);
  assign acc        = item_valid && item_ready;
  assign src_go     = acc && item.func == FUNC_SRC && run_st == ST_RUN;
  assign rd_go      = acc && item.func == FUNC_READ;
  assign b          = item.data_byte;
  assign off_val    = {b, offlo};
  assign space      = block_cap - prod;
  assign new_cap    = cap_of(cfg_cap);
  assign copy_end   = prod + CW'(mlen);
  assign in_range   = (RW'(item.read_addr) < RW'(prod)) &&
                      (RW'(item.read_addr) < RW'(OUT_CAP));

  // saturating length accumulate
  assign sum_w   = SW'(len) + SW'(b);
  assign sat_len = (sum_w > SW'(LenSat)) ? LW'(LenSat) : LW'(sum_w);

  // shared length operand and compare against space left
  always_comb begin
    case (phase)
      PH_TOKEN:    cmp_len = LW'(b[7:4]);
      PH_LITLEN:   cmp_len = sat_len;
      PH_OFF_HI:   cmp_len = LW'(nib) + LW'(MinMatch);
      PH_MATCHLEN: cmp_len = sat_len + LW'(MinMatch);
      default:     cmp_len = '0;
    endcase
  end
  assign too_long = cmp_len > LW'(space);

  // sequence parser for one source byte
  always_comb begin
    phase_next  = phase;
    len_next    = len;
    nib_next    = nib;
    offlo_next  = offlo;
    off_next    = off;
    status_next = run_st;
    prod_next   = prod;
    begin_lit   = 1'b0;
    do_match    = 1'b0;
    lit_we      = 1'b0;
    copy_go     = 1'b0;
    if (src_go) begin
      unique case (phase)
        PH_TOKEN: begin
          nib_next = b[3:0];
          len_next = LW'(b[7:4]);
          if (b[7:4] == 4'hF) begin
            if (item.last) status_next = ST_ERR;
            else           phase_next  = PH_LITLEN;
          end else begin
            begin_lit = 1'b1;
          end
        end
        PH_LITLEN: begin
          len_next = sat_len;
          if (b == 8'hFF) begin
            if (item.last) status_next = ST_ERR;
          end else begin
            begin_lit = 1'b1;
          end
        end
        PH_LITERALS: begin
          lit_we    = 1'b1;
          prod_next = prod + CW'(1);
          len_next  = len - LW'(1);
          if (len == LW'(1)) begin
            if (prod_next >= block_cap || item.last) status_next = ST_DONE;
            else                                     phase_next  = PH_OFF_LO;
          end else if (item.last) begin
            status_next = ST_ERR;
          end
        end
        PH_OFF_LO: begin
          offlo_next = b;
          if (item.last) status_next = ST_ERR;
          else           phase_next  = PH_OFF_HI;
        end
        PH_OFF_HI: begin
          off_next = off_val;
          if (off_val == 16'd0 || OW'(off_val) > OW'(prod)) begin
            status_next = ST_ERR;
          end else if (nib == 4'hF) begin
            len_next = LW'(15);
            if (item.last) status_next = ST_ERR;
            else           phase_next  = PH_MATCHLEN;
          end else begin
            do_match = 1'b1;
          end
        end
        PH_MATCHLEN: begin
          len_next = sat_len;
          if (b == 8'hFF) begin
            if (item.last) status_next = ST_ERR;
          end else begin
            do_match = 1'b1;
          end
        end
        default: status_next = ST_ERR;
      endcase

      // literal run start
      if (begin_lit) begin
        if (too_long) begin
          status_next = ST_ERR;
        end else if (cmp_len == '0) begin
          if (prod >= block_cap || item.last) status_next = ST_DONE;
          else                                phase_next  = PH_OFF_LO;
        end else if (item.last) begin
          status_next = ST_ERR;
        end else begin
          len_next   = cmp_len;
          phase_next = PH_LITERALS;
        end
      end

      // match start
      if (do_match) begin
        if (too_long) status_next = ST_ERR;
        else          copy_go     = 1'b1;
      end
    end
  end

  // history port arbitration
  assign ram_we    = copy_we || lit_we;
  assign ram_waddr = copy_we ? copy_waddr : AW'(prod);
  assign ram_wdata = copy_we ? copy_wdata : b;
  assign ram_re    = copy_re || rd_go;
  assign ram_raddr = copy_re ? copy_raddr : AW'(item.read_addr);

  lz4bd_ram #(
    .W (8),
    .D (OUT_CAP)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lz4bd_copy #(
    .OUT_CAP (OUT_CAP)
  ) u_copy (
    .clk      (clk),
    .rst      (rst),
    .start    (copy_go),
    .src_base (AW'(prod - CW'(off_next))),
    .dst_base (AW'(prod)),
    .count    (cmp_len),
    .rdata    (ram_rdata),
    .re       (copy_re),
    .raddr    (copy_raddr),
    .we       (copy_we),
    .waddr    (copy_waddr),
    .wdata    (copy_wdata),
    .stat     (cstat)
  );

  // control FSM, block state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      cfg_cap   <= 13'(CapReset);
      block_cap <= cap_of(13'(CapReset));
      prod      <= '0;
      phase     <= PH_TOKEN;
      len       <= '0;
      nib       <= '0;
      offlo     <= '0;
      off       <= '0;
      run_st    <= ST_RUN;
    end else begin
      if (cfg_we) begin
        cfg_cap <= cfg_wdata;
      end
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            case (item.func)
              FUNC_START: begin
                block_cap      <= new_cap;
                prod           <= '0;
                phase          <= PH_TOKEN;
                len            <= '0;
                nib            <= '0;
                offlo          <= '0;
                off            <= '0;
                run_st         <= (new_cap == '0) ? ST_DONE : ST_RUN;
                res_valid      <= 1'b1;
                res.status     <= (new_cap == '0) ? ST_DONE : ST_RUN;
                res.read_data  <= '0;
                res.out_length <= '0;
              end
              FUNC_SRC: begin
                phase  <= phase_next;
                len    <= len_next;
                nib    <= nib_next;
                offlo  <= offlo_next;
                off    <= off_next;
                run_st <= status_next;
                prod   <= prod_next;
                if (copy_go) begin
                  state  <= S_COPY;
                  mlen   <= cmp_len;
                  last_q <= item.last;
                end else begin
                  res_valid      <= 1'b1;
                  res.status     <= status_next;
                  res.read_data  <= '0;
                  res.out_length <= 13'(prod_next);
                end
              end
              FUNC_READ: begin
                state  <= S_READ;
                rd_hit <= in_range;
              end
              default: begin
                res_valid      <= 1'b1;
                res.status     <= run_st;
                res.read_data  <= '0;
                res.out_length <= 13'(prod);
              end
            endcase
          end
        end
        S_READ: begin
          res_valid      <= 1'b1;
          res.status     <= run_st;
          res.read_data  <= rd_hit ? ram_rdata : 8'd0;
          res.out_length <= 13'(prod);
          state          <= S_IDLE;
        end
        S_COPY: begin
          if (cstat.done) begin
            prod <= copy_end;
            if (copy_end >= block_cap || last_q) begin
              run_st     <= ST_DONE;
              res.status <= ST_DONE;
            end else begin
              phase      <= PH_TOKEN;
              res.status <= run_st;
            end
            res_valid      <= 1'b1;
            res.read_data  <= '0;
            res.out_length <= 13'(copy_end);
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/lz4bd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lz4bd_ram import lz4bd_pkg::*; #(
  parameter int W = 8,
  parameter int D = OutCapDefault
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/lz4bd_copy.sv =====
// Match copy engine: one history byte read and written per cycle.
module lz4bd_copy import lz4bd_pkg::*; #(
  parameter int OUT_CAP = OutCapDefault
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [$clog2(OUT_CAP)-1:0] src_base,
  input  logic [$clog2(OUT_CAP)-1:0] dst_base,
  input  logic [$clog2(OUT_CAP+6)-1:0] count,
  input  logic [7:0]                 rdata,
  output logic                       re,
  output logic [$clog2(OUT_CAP)-1:0] raddr,
  output logic                       we,
  output logic [$clog2(OUT_CAP)-1:0] waddr,
  output logic [7:0]                 wdata,
  output lz4bd_copy_stat_t           stat
);

  localparam int AW = $clog2(OUT_CAP);
  localparam int LW = $clog2(OUT_CAP + 6);

  typedef enum logic {C_IDLE, C_RUN} cst_t;

  cst_t          cst;
  logic [AW-1:0] src;
  logic [AW-1:0] dst;
  logic [LW-1:0] rem;
  logic          fwd;
  logic [7:0]    fwd_byte;
  logic [AW-1:0] src_inc;
  logic          last_byte;

  assign src_inc   = src + AW'(1);
  assign last_byte = (rem == LW'(1));

  // read the next source byte while writing the current one
  always_comb begin
    re        = start || (cst == C_RUN && !last_byte);
    raddr     = start ? src_base : src_inc;
    we        = (cst == C_RUN);
    waddr     = dst;
    // offset of one reads the byte being written: take it from the bypass
    wdata     = fwd ? fwd_byte : rdata;
    stat.busy = (cst == C_RUN);
    stat.done = (cst == C_RUN) && last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cst <= C_IDLE;
      fwd <= 1'b0;
    end else begin
      unique case (cst)
        C_IDLE: begin
          if (start) begin
            src <= src_base;
            dst <= dst_base;
            rem <= count;
            fwd <= 1'b0;
            cst <= C_RUN;
          end
        end
        C_RUN: begin
          src      <= src_inc;
          dst      <= dst + AW'(1);
          rem      <= rem - LW'(1);
          fwd      <= (src_inc == dst);
          fwd_byte <= wdata;
          if (last_byte) begin
            cst <= C_IDLE;
          end
        end
        default: cst <= C_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/lz4bd_checker.sv =====
// Port-level checks for the LZ4 block decompressor, bound to the top level.
module lz4bd_checker import lz4bd_pkg::*; (
  input logic          clk,
  input logic          rst,
  input logic          item_valid,
  input logic          item_ready,
  input lz4bd_item_t   item,
  input logic          res_valid,
  input logic          res_ready,
  input lz4bd_result_t res
);

  logic acc;
  assign acc = item_valid && item_ready;

  // no request is taken while a result is stalled
  a_no_take_on_stall: assert property (@(posedge clk) disable iff (rst)
    !(item_ready && res_valid && !res_ready))
    else $error("request taken while result stalled");

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("stalled result changed");

  // a start request returns an empty block next cycle
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    acc && item.func == FUNC_START |=>
      res_valid && res.out_length == 13'd0 && res.status != ST_ERR)
    else $error("start result wrong");

  // a read returns after the RAM read register
  a_read_timing: assert property (@(posedge clk) disable iff (rst)
    acc && item.func == FUNC_READ |=> !res_valid ##1 res_valid)
    else $error("read result timing wrong");

endmodule

bind lz4_block_decompressor_core lz4bd_checker u_lz4bd_checker (.*);

// ===== sim/lz4_block_decompressor_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the LZ4 block decompressor core with its own decoder model.
module lz4_block_decompressor_core_tb;
  import lz4bd_pkg::*;

  localparam int          CAP_LIMIT  = OutCapDefault;
  localparam int unsigned LEN_CLAMP  = CAP_LIMIT + 1;
  localparam logic [1:0]  FUNC_NONE  = 2'd3;
  localparam int          RND_ITEMS  = 750;
  localparam int          HOLD_LEN   = 120;
  localparam int          IDLE_PCT   = 38;

  // decoder sequence phases
  typedef enum logic [2:0] {
    SEQ_TOKEN, SEQ_LITLEN, SEQ_LITS, SEQ_OFF_LO, SEQ_OFF_HI, SEQ_MLEN
  } seq_phase_t;

  // directed stimulus row; pinned rows carry a hand-written result
  typedef struct {
    lz4bd_item_t   req;
    bit            pinned;
    lz4bd_result_t want;
  } dir_row_t;

  typedef struct {
    bit            pinned;
    lz4bd_result_t want;
  } pin_tag_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          item_valid = 1'b0;
  logic          item_ready;
  lz4bd_item_t   item = '0;
  logic          res_valid;
  logic          res_ready = 1'b0;
  lz4bd_result_t res;
  logic          cfg_we = 1'b0;
  logic [12:0]   cfg_wdata = '0;

  lz4_block_decompressor_core #(.OUT_CAP(CAP_LIMIT)) DUT (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------
  // decoder model state
  logic [7:0]    hist [0:CAP_LIMIT-1];
  int unsigned   prod;
  int unsigned   len_acc;
  int unsigned   m_nib;
  int unsigned   off_lo;
  int unsigned   m_off;
  int unsigned   blk_cap;
  int unsigned   cap_reg;
  logic [1:0]    run_st;
  seq_phase_t    seq_ph;

  lz4bd_result_t due_results [$];
  pin_tag_t      pin_tags [$];
  dir_row_t      dir_rows [$];
  int            fails = 0;
  int            n_sent = 0;
  int            n_done = 0;
  int            rnd_items = 0;
  bit            calm = 1'b0;
  bit            mangle = 1'b0;
  int            hold_req = 0;
  int            hold_seen = 0;
  int            hold_left = 0;

  function automatic int unsigned room_left();
    return (blk_cap > prod) ? blk_cap - prod : 0;
  endfunction

  function automatic int unsigned len_add(input int unsigned a, input int unsigned b);
    return (a + b > LEN_CLAMP) ? LEN_CLAMP : a + b;
  endfunction

  function automatic void new_block();
    blk_cap = (cap_reg > CAP_LIMIT) ? CAP_LIMIT : cap_reg;
    prod    = 0;
    seq_ph  = SEQ_TOKEN;
    len_acc = 0;
    m_nib   = 0;
    off_lo  = 0;
    m_off   = 0;
    run_st  = (blk_cap == 0) ? ST_DONE : ST_RUN;
  endfunction

  // end of literals or match: done on full output or last byte
  function automatic void part_end(input bit lastf, input seq_phase_t nxt);
    if (prod >= blk_cap || lastf) run_st = ST_DONE;
    else seq_ph = nxt;
  endfunction

  function automatic void open_literals(input int unsigned n, input bit lastf);
    if (n > room_left()) run_st = ST_ERR;
    else if (n == 0) part_end(lastf, SEQ_OFF_LO);
    else if (lastf) run_st = ST_ERR;
    else begin
      len_acc = n;
      seq_ph  = SEQ_LITS;
    end
  endfunction

  // byte-wise copy so overlapping matches repeat data
  function automatic void copy_match(input int unsigned n, input bit lastf);
    int unsigned i;
    if (n > room_left()) begin
      run_st = ST_ERR;
      return;
    end
    for (i = 0; i < n; i++) begin
      if (prod < CAP_LIMIT) hist[prod] = hist[prod - m_off];
      prod++;
    end
    part_end(lastf, SEQ_TOKEN);
  endfunction

  function automatic void take_byte(input int unsigned b, input bit lastf);
    case (seq_ph)
      SEQ_TOKEN: begin
        m_nib   = b & 'h0F;
        len_acc = b >> 4;
        if (len_acc == 15) begin
          if (lastf) run_st = ST_ERR;
          else seq_ph = SEQ_LITLEN;
        end else begin
          open_literals(len_acc, lastf);
        end
      end
      SEQ_LITLEN: begin
        len_acc = len_add(len_acc, b);
        if (b == 255) begin
          if (lastf) run_st = ST_ERR;
        end else begin
          open_literals(len_acc, lastf);
        end
      end
      SEQ_LITS: begin
        if (prod < CAP_LIMIT) hist[prod] = b[7:0];
        prod++;
        len_acc--;
        if (len_acc == 0) part_end(lastf, SEQ_OFF_LO);
        else if (lastf) run_st = ST_ERR;
      end
      SEQ_OFF_LO: begin
        off_lo = b;
        if (lastf) run_st = ST_ERR;
        else seq_ph = SEQ_OFF_HI;
      end
      SEQ_OFF_HI: begin
        m_off = off_lo | (b << 8);
        if (m_off == 0 || m_off > prod) begin
          run_st = ST_ERR;
        end else if (m_nib == 15) begin
          len_acc = 15;
          if (lastf) run_st = ST_ERR;
          else seq_ph = SEQ_MLEN;
        end else begin
          copy_match(m_nib + MinMatch, lastf);
        end
      end
      SEQ_MLEN: begin
        len_acc = len_add(len_acc, b);
        if (b == 255) begin
          if (lastf) run_st = ST_ERR;
        end else begin
          copy_match(len_acc + MinMatch, lastf);
        end
      end
      default: run_st = ST_ERR;
    endcase
  endfunction

  // one request in, one predicted result out
  function automatic lz4bd_result_t decode_step(input lz4bd_item_t r);
    lz4bd_result_t o;
    o.read_data = 8'h00;
    case (r.func)
      FUNC_START: new_block();
      FUNC_SRC:   if (run_st == ST_RUN) take_byte(r.data_byte, r.last);
      FUNC_READ:  if (r.read_addr < prod) o.read_data = hist[r.read_addr];
      default: ;
    endcase
    o.status     = run_st;
    o.out_length = prod[12:0];
    return o;
  endfunction

  // ---------------------------------------------------------------------
  task automatic report_miss(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, want %0d (result %0d)", what, got, want, n_done);
    fails++;
  endtask

  // request and result monitor
  always @(posedge clk) begin
    pin_tag_t      tag;
    lz4bd_result_t got;
    lz4bd_result_t w;
    if (!rst) begin
      if (cfg_we) cap_reg = cfg_wdata;
      if (item_valid && item_ready) begin
        tag = pin_tags.pop_front();
        got = decode_step(item);
        due_results.push_back(tag.pinned ? tag.want : got);
      end
      if (res_valid && res_ready) begin
        if (due_results.size() == 0) begin
          report_miss("result with no request pending", res, 0);
        end else begin
          w = due_results.pop_front();
          if (res.status != w.status) report_miss("status", res.status, w.status);
          if (res.read_data != w.read_data)
            report_miss("read_data", res.read_data, w.read_data);
          if (res.out_length != w.out_length)
            report_miss("out_length", res.out_length, w.out_length);
        end
        n_done++;
      end
    end
  end

  // result side: random stalls, a long hold on request, calm stretches
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_LEN;
      res_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_ready <= 1'b0;
    end else if (calm) begin
      res_ready <= 1'b1;
    end else begin
      res_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------
  // request driver; called and returning right after a rising edge
  task automatic send_req(input lz4bd_item_t r, input bit pin, input lz4bd_result_t want);
    pin_tag_t tag;
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    tag.pinned = pin;
    tag.want   = want;
    pin_tags.push_back(tag);
    item_valid <= 1'b1;
    item       <= r;
    do @(posedge clk); while (!item_ready);
    n_sent++;
  endtask

  task automatic offer(input logic [1:0] f, input logic [7:0] d, input logic l,
                       input logic [11:0] a);
    lz4bd_item_t r;
    r.func      = f;
    r.data_byte = d;
    r.last      = l;
    r.read_addr = a;
    send_req(r, 1'b0, '0);
    rnd_items++;
  endtask

  // source byte with reads and unused codes mixed in; optional corruption
  task automatic put_src(input logic [7:0] b, input bit lastf);
    logic [7:0] v;
    bit         l;
    v = b;
    l = lastf;
    if ($urandom_range(0, 11) == 0)
      offer(FUNC_READ, 8'($urandom), 1'($urandom),
            $urandom_range(0, 1) ? 12'($urandom) : 12'($urandom_range(0, 63)));
    if ($urandom_range(0, 79) == 0)
      offer(FUNC_NONE, 8'($urandom), 1'($urandom), 12'($urandom));
    if (mangle && $urandom_range(0, 24) == 0) v = 8'($urandom);
    if (mangle && $urandom_range(0, 39) == 0) l = 1'b1;
    offer(FUNC_SRC, v, l, 12'($urandom));
  endtask

  // chained length bytes
  task automatic put_ext(input int unsigned rest, input bit lastf);
    while (rest >= 255) begin
      put_src(8'hFF, 1'b0);
      rest -= 255;
    end
    put_src(rest[7:0], lastf);
  endtask

  // one well-formed block that fits the capacity, then a few reads
  task automatic run_block(input int unsigned cap);
    int unsigned made, room, lit, mlen, off, nseq, k, i, lim;
    bit          fin, end_m;
    logic [3:0]  ln, mn;
    offer(FUNC_START, 8'($urandom), 1'($urandom), 12'($urandom));
    made = 0;
    nseq = $urandom_range(1, 5);
    for (k = 0; k < nseq; k++) begin
      room = cap - made;
      if (room == 0) break;
      lit = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 14);
      if (made == 0 && lit == 0) lit = 1;
      if (lit > room) lit = room;
      end_m = (k == nseq - 1) && ($urandom_range(0, 1) == 1);
      fin   = ((k == nseq - 1) && !end_m) || (room - lit < MinMatch);
      mlen  = ($urandom_range(0, 7) == 0) ? $urandom_range(19, 300) : $urandom_range(4, 18);
      if (!fin && mlen > room - lit) mlen = room - lit;
      ln = (lit < 15) ? lit[3:0] : 4'hF;
      if (fin) mn = 4'($urandom);
      else mn = (mlen - MinMatch < 15) ? 4'(mlen - MinMatch) : 4'hF;
      put_src({ln, mn}, fin && lit == 0);
      if (lit >= 15) put_ext(lit - 15, 1'b0);
      for (i = 0; i < lit; i++) put_src(8'($urandom), fin && i == lit - 1);
      made += lit;
      if (fin) break;
      // short offsets often, for overlapping copies
      lim = (made < 4) ? made : 4;
      off = ($urandom_range(0, 1) == 1) ? $urandom_range(1, lim) : $urandom_range(1, made);
      put_src(off[7:0], 1'b0);
      put_src(off[15:8], end_m && mn != 4'hF);
      if (mn == 4'hF) put_ext(mlen - MinMatch - 15, end_m);
      made += mlen;
      if (end_m) break;
    end
    lim = (made > 4095) ? 4095 : made;
    repeat ($urandom_range(1, 3)) offer(FUNC_READ, 8'($urandom), 1'($urandom),
                                        12'($urandom_range(0, lim)));
  endtask

  // stop offering and wait until every result is back
  task automatic settle();
    item_valid <= 1'b0;
    while (n_done != n_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cap(input logic [12:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_row(input logic [1:0] f, input logic [7:0] d, input logic l,
                         input logic [11:0] a, input bit pin, input logic [1:0] st,
                         input logic [7:0] rd, input logic [12:0] len);
    dir_row_t row;
    row.req.func        = f;
    row.req.data_byte   = d;
    row.req.last        = l;
    row.req.read_addr   = a;
    row.pinned          = pin;
    row.want.status     = st;
    row.want.read_data  = rd;
    row.want.out_length = len;
    dir_rows.push_back(row);
  endtask

  // ---------------------------------------------------------------------
  initial begin
    logic [12:0] caps [10];
    int          phase_no;
    int          goal;
    int          kind;
    int unsigned gcap;

    caps = '{13'd0, 13'd4096, 13'd16, 13'd1, 13'd4095, 13'd300, 13'd4, 13'd64,
             13'd1000, 13'd37};
    cap_reg = CapReset;
    new_block();

    // directed table
    add_row(FUNC_READ, 8'h00, 1'b0, 12'h000, 1, ST_RUN, 8'h00, 13'd0);
    add_row(FUNC_NONE, 8'hAA, 1'b1, 12'hFFF, 1, ST_RUN, 8'h00, 13'd0);
    // bytes before any start: one literal, then an offset-1 match
    add_row(FUNC_SRC, 8'h10, 1'b0, 12'h000, 0, ST_RUN, 8'h00, 13'd0);
    add_row(FUNC_SRC, 8'hFF, 1'b0, 12'h000, 0, ST_RUN, 8'h00, 13'd0);
    add_row(FUNC_SRC, 8'h01, 1'b0, 12'h000, 0, ST_RUN, 8'h00, 13'd0);
    add_row(FUNC_SRC, 8'h00, 1'b0, 12'h000, 0, ST_RUN, 8'h00, 13'd0);
    // no literals, chained match length, ends after the match
    add_row(FUNC_SRC, 8'h0F, 1'b0, 12'h000, 0, ST_RUN, 8'h00, 13'd0);
    add_row(FUNC_SRC, 8'h05, 1'b0, 12'h000, 0, ST_RUN, 8'h00, 13'd0);
    add_row(FUNC_SRC, 8'h00, 1'b0, 12'h000, 0, ST_RUN, 8'h00, 13'd0);
    add_row(FUNC_SRC, 8'hFF, 1'b0, 12'h000, 0, ST_RUN, 8'h00, 13'd0);
    add_row(FUNC_SRC, 8'h00, 1'b1, 12'h000, 0, ST_RUN, 8'h00, 13'd0);
    add_row(FUNC_READ, 8'h00, 1'b0, 12'd278, 0, ST_RUN, 8'h00, 13'd0);
    add_row(FUNC_READ, 8'h00, 1'b0, 12'hFFF, 0, ST_RUN, 8'h00, 13'd0);
    // source after done is ignored
    add_row(FUNC_SRC, 8'h55, 1'b0, 12'h000, 0, ST_RUN, 8'h00, 13'd0);
    // empty block
    add_row(FUNC_START, 8'h00, 1'b0, 12'h000, 1, ST_RUN, 8'h00, 13'd0);
    add_row(FUNC_SRC, 8'h00, 1'b1, 12'h000, 1, ST_DONE, 8'h00, 13'd0);
    // zero offset
    add_row(FUNC_START, 8'h00, 1'b0, 12'h000, 1, ST_RUN, 8'h00, 13'd0);
    add_row(FUNC_SRC, 8'h00, 1'b0, 12'h000, 1, ST_RUN, 8'h00, 13'd0);
    add_row(FUNC_SRC, 8'h00, 1'b0, 12'h000, 1, ST_RUN, 8'h00, 13'd0);
    add_row(FUNC_SRC, 8'h00, 1'b0, 12'h000, 1, ST_ERR, 8'h00, 13'd0);
    // source ends inside a chained literal length
    add_row(FUNC_START, 8'h00, 1'b0, 12'h000, 1, ST_RUN, 8'h00, 13'd0);
    add_row(FUNC_SRC, 8'hF0, 1'b0, 12'h000, 1, ST_RUN, 8'h00, 13'd0);
    add_row(FUNC_SRC, 8'hFF, 1'b1, 12'h000, 1, ST_ERR, 8'h00, 13'd0);
    add_row(FUNC_READ, 8'h00, 1'b0, 12'h000, 1, ST_ERR, 8'h00, 13'd0);
    add_row(FUNC_SRC, 8'h80, 1'b0, 12'h000, 1, ST_ERR, 8'h00, 13'd0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].pinned, dir_rows[i].want);

    // random phases, one capacity setting each
    phase_no = 0;
    while (rnd_items < RND_ITEMS || phase_no < 10) begin
      write_cap(caps[phase_no % 10]);
      gcap = (caps[phase_no % 10] > CAP_LIMIT) ? CAP_LIMIT : caps[phase_no % 10];
      calm <= (phase_no == 3);
      if (phase_no == 1) hold_req <= hold_req + 1;
      // fixed share of the total per phase, at least one block each
      goal = (phase_no + 1) * (RND_ITEMS / 10);
      do begin
        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
          run_block(gcap);
        end else if (kind == 7) begin
          mangle = 1'b1;
          run_block(gcap);
          mangle = 1'b0;
        end else if (kind == 8) begin
          // saturating literal length chain
          offer(FUNC_START, 8'h00, 1'b0, 12'h000);
          put_src({4'hF, 4'($urandom)}, 1'b0);
          repeat ($urandom_range(16, 20)) put_src(8'hFF, 1'b0);
          put_src(8'($urandom_range(0, 254)), 1'($urandom));
        end else begin
          // raw bytes
          offer(FUNC_START, 8'h00, 1'b0, 12'h000);
          repeat ($urandom_range(3, 12)) put_src(8'($urandom), $urandom_range(0, 9) == 0);
        end
      end while (rnd_items < goal);
      phase_no++;
    end

    settle();
    repeat (20) @(posedge clk);
    if (due_results.size() != 0) report_miss("results never returned", 0, due_results.size());
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== lz4_block_decompressor_core.f =====
rtl/lz4bd_pkg.sv
rtl/lz4bd_ram.sv
rtl/lz4bd_copy.sv
rtl/lz4_block_decompressor_core.sv
rtl/lz4bd_checker.sv
sim/lz4_block_decompressor_core_tb.sv
